FILE: hdl/spe_pkg.sv
// Shared types, constants and helpers for the spline point evaluator.
`default_nettype none

package spe_pkg;

  // Default sizes handed to the top level
  localparam int MAX_KNOTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int FIELD_BITS = 32;
  localparam int INDEX_BITS = 6;
  localparam int COUNT_BITS = 7;
  localparam int PARAM_BITS = 17;
  localparam int FRAC_BITS  = 16;

  // Blend weights: signed, split into a low unsigned and a high signed half
  localparam int WEIGHT_BITS = 52;
  localparam int WLO_BITS    = 26;
  localparam int MREG_BITS   = 50;

  // Shared multiplier operand widths
  localparam int MUL_A_BITS = 35;
  localparam int MUL_B_BITS = 27;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  localparam logic [PARAM_BITS-1:0] ONE_Q16 = 17'h10000;
  localparam int SHIFT_BEZIER  = 48;
  localparam int SHIFT_CATMULL = 49;

  // Sequencing lengths
  localparam int WSTEPS     = 6;
  localparam int BSTEPS     = 12;
  localparam int BLEND_TAPS = 4;

  // Codes
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_EVAL     = 1'b1;
  localparam logic MODE_BEZIER  = 1'b0;
  localparam logic MODE_CATMULL = 1'b1;
  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_KNOTS    = 1'b1;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FEW   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic                          command;
    logic [INDEX_BITS-1:0]         knot_index;
    logic signed [FIELD_BITS-1:0]  knot_x;
    logic signed [FIELD_BITS-1:0]  knot_y;
    logic signed [FIELD_BITS-1:0]  knot_z;
    logic [PARAM_BITS-1:0]         curve_param;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] point_x;
    logic signed [FIELD_BITS-1:0] point_y;
    logic signed [FIELD_BITS-1:0] point_z;
    logic [1:0]                   status;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_PARAM, OP_SPLIT,
    OP_WMUL, OP_WFIN, OP_READ, OP_BLEND, OP_ROUND
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] step;
    logic [1:0] knot;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
  } dp_stat_t;

  // Segment count (n-1)/3 for n-1 below 128: multiply by 43, drop 7 bits
  function automatic logic [5:0] div3(input logic [COUNT_BITS-1:0] x);
    logic [12:0] p;
    p = 13'(x) * 13'd43;
    return p[12:7];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/spe_ctrl.sv
// Sequencer for the spline point evaluator: steps the datapath through one item.
`default_nettype none

module spe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire spe_pkg::dp_stat_t stat,
  output spe_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   done
);
  import spe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PARAM, S_SPLIT, S_WMUL, S_WCAP,
    S_WFIN, S_READ, S_BLEND, S_DRAIN, S_ROUND
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic [1:0] knot;

  // Decode the datapath command from the state
  always_comb begin
    cmd.step = step;
    cmd.knot = knot;
    unique case (state)
      S_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
      S_CHECK: cmd.op = OP_CHECK;
      S_PARAM: cmd.op = OP_PARAM;
      S_SPLIT: cmd.op = OP_SPLIT;
      S_WMUL:  cmd.op = OP_WMUL;
      S_WFIN:  cmd.op = OP_WFIN;
      S_READ:  cmd.op = OP_READ;
      S_BLEND: cmd.op = OP_BLEND;
      S_ROUND: cmd.op = OP_ROUND;
      default: cmd.op = OP_NONE;
    endcase
  end

  // Advance state, counters and handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      knot  <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.finish) begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_PARAM;
          end
        end
        S_PARAM: state <= S_SPLIT;
        S_SPLIT: begin
          step  <= '0;
          state <= S_WMUL;
        end
        S_WMUL: begin
          if (step == 4'(WSTEPS - 1)) begin
            step  <= '0;
            state <= S_WCAP;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_WCAP: state <= S_WFIN;
        S_WFIN: begin
          knot  <= '0;
          state <= S_READ;
        end
        S_READ: begin
          step  <= '0;
          state <= S_BLEND;
        end
        S_BLEND: begin
          if (step == 4'(BSTEPS - 1)) begin
            step <= '0;
            if (knot == 2'(BLEND_TAPS - 1)) begin
              state <= S_DRAIN;
            end else begin
              knot  <= knot + 2'd1;
              state <= S_READ;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DRAIN: state <= S_ROUND;
        S_ROUND: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A taken item makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // One result per item: the strobe is never raised twice in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // The block is free again while its result is shown
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && state == S_IDLE))
    else $error("result strobe while still busy");

endmodule

`default_nettype wire

FILE: hdl/spe_datapath.sv
// Datapath for the spline point evaluator: knot memory, shared multiplier, accumulators.
`default_nettype none

module spe_datapath #(
  parameter int MAX_KNOTS  = spe_pkg::MAX_KNOTS_DEF,
  parameter int COORD_BITS = spe_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spe_pkg::item_t                item,
  input  wire logic                          wr_en,
  input  wire logic                          wr_index,
  input  wire logic [spe_pkg::COUNT_BITS-1:0] wr_data,
  input  wire spe_pkg::dp_cmd_t              cmd,
  output spe_pkg::dp_stat_t                  stat,
  output spe_pkg::result_t                   result
);
  import spe_pkg::*;

  localparam int IW   = $clog2(MAX_KNOTS);
  localparam int C    = COORD_BITS;
  localparam int CL   = C / 2;
  localparam int ACCW = WEIGHT_BITS + C + 2;
  localparam logic signed [ACCW-1:0] CMAX = (ACCW'(1) << (C - 1)) - ACCW'(1);
  localparam logic signed [ACCW-1:0] CMIN = -CMAX - ACCW'(1);
  localparam logic signed [48:0] KMAX = (49'(1) << (C - 1)) - 49'(1);
  localparam logic signed [48:0] KMIN = -KMAX - 49'(1);

  // Configuration
  logic                  cfg_mode;
  logic [COUNT_BITS-1:0] cfg_knots;

  // Item and segment state
  item_t                  item_q;
  logic [5:0]             s_q;
  logic [22:0]            tn_q;
  logic [PARAM_BITS-1:0]  u_q;
  logic [PARAM_BITS-1:0]  l_q;
  logic [COUNT_BITS-1:0]  idx_q [BLEND_TAPS];
  logic [MREG_BITS-1:0]   m_q [WSTEPS];
  logic signed [WEIGHT_BITS-1:0] w_q [BLEND_TAPS];

  // Knot memory
  logic [3*C-1:0] knot_mem [MAX_KNOTS];
  logic [3*C-1:0] rd_q;

  // Multiplier pipeline
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [MUL_P_BITS-1:0] prod_q;
  logic                         pvalid;
  logic                         pblend;
  logic [3:0]                   ptag;

  logic signed [ACCW-1:0] acc_q [3];
  result_t                result_q;

  // Saturate a 32-bit coordinate into the stored width
  function automatic logic signed [C-1:0] sat_knot(input logic signed [FIELD_BITS-1:0] v);
    logic signed [48:0] e;
    e = 49'(v);
    if (e > KMAX) begin
      return C'(KMAX);
    end else if (e < KMIN) begin
      return C'(KMIN);
    end
    return C'(e);
  endfunction

  // Round, shift down and saturate one accumulator
  function automatic logic signed [FIELD_BITS-1:0] finish_axis(
      input logic signed [ACCW-1:0] a, input logic mode);
    logic signed [ACCW-1:0] rnd;
    logic signed [ACCW-1:0] r;
    logic signed [C-1:0]    s;
    if (mode == MODE_CATMULL) begin
      rnd = a + (ACCW'(1) << (SHIFT_CATMULL - 1));
      r   = rnd >>> SHIFT_CATMULL;
    end else begin
      rnd = a + (ACCW'(1) << (SHIFT_BEZIER - 1));
      r   = rnd >>> SHIFT_BEZIER;
    end
    if (r > CMAX) begin
      s = C'(CMAX);
    end else if (r < CMIN) begin
      s = C'(CMIN);
    end else begin
      s = C'(r);
    end
    return FIELD_BITS'(s);
  endfunction

  // Checks on the held item
  logic                  is_write, slot_bad, n_bad, few;
  logic [1:0]            status_c;
  logic [PARAM_BITS-1:0] t_sat;
  logic [COUNT_BITS-1:0] nm1;

  always_comb begin
    is_write = (item_q.command == CMD_WRITE);
    slot_bad = int'(item_q.knot_index) >= MAX_KNOTS;
    n_bad    = int'(cfg_knots) > MAX_KNOTS;
    few      = (cfg_mode == MODE_BEZIER) ? (cfg_knots < COUNT_BITS'(4))
                                         : (cfg_knots == '0);
    if (is_write) begin
      status_c = slot_bad ? STATUS_RANGE : STATUS_OK;
    end else begin
      status_c = n_bad ? STATUS_RANGE : STATUS_FEW;
    end
    stat.finish = is_write || n_bad || few;
    t_sat = (item_q.curve_param > ONE_Q16) ? ONE_Q16 : item_q.curve_param;
    nm1   = cfg_knots - COUNT_BITS'(1);
  end

  // Segment split: Bezier local parameter or Catmull-Rom span and clamped taps
  logic [22:0]            ts;
  logic [5:0]             seg, smax;
  logic [22:0]            lw;
  logic [COUNT_BITS-1:0]  p1, i0, i2, i3;
  logic [COUNT_BITS-1:0]  seg7;

  always_comb begin
    ts   = 23'(t_sat) * 23'(s_q);
    smax = s_q - 6'd1;
    seg  = (ts[22:16] > 7'(smax)) ? smax : ts[21:16];
    lw   = ts - (23'(seg) << FRAC_BITS);
    seg7 = 7'(seg) * 7'd3;
    p1   = tn_q[22:16];
    i0   = (p1 == '0) ? p1 : p1 - 7'd1;
    i2   = (p1 == nm1) ? p1 : p1 + 7'd1;
    i3   = (i2 == nm1) ? i2 : i2 + 7'd1;
  end

  // Select the multiplier operands for the current step
  logic signed [WEIGHT_BITS-1:0] wsel;
  logic signed [C-1:0]           csel;

  always_comb begin
    wsel  = w_q[cmd.knot];
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step[3:2])
      2'd1:    csel = rd_q[C +: C];
      2'd2:    csel = rd_q[2*C +: C];
      default: csel = rd_q[0 +: C];
    endcase
    if (cmd.op == OP_BLEND) begin
      // Low halves are unsigned, high halves carry the sign
      unique case (cmd.step[1:0])
        2'd0: begin
          mul_a = MUL_A_BITS'({1'b0, csel[CL-1:0]});
          mul_b = MUL_B_BITS'({1'b0, wsel[WLO_BITS-1:0]});
        end
        2'd1: begin
          mul_a = MUL_A_BITS'($signed(csel[C-1:CL]));
          mul_b = MUL_B_BITS'({1'b0, wsel[WLO_BITS-1:0]});
        end
        2'd2: begin
          mul_a = MUL_A_BITS'({1'b0, csel[CL-1:0]});
          mul_b = MUL_B_BITS'($signed(wsel[WEIGHT_BITS-1:WLO_BITS]));
        end
        default: begin
          mul_a = MUL_A_BITS'($signed(csel[C-1:CL]));
          mul_b = MUL_B_BITS'($signed(wsel[WEIGHT_BITS-1:WLO_BITS]));
        end
      endcase
    end else begin
      // Power products: u*u, l*l, u2*u, u2*l, l2*u, l2*l
      unique case (cmd.step)
        4'd0: begin
          mul_a = MUL_A_BITS'(u_q);
          mul_b = MUL_B_BITS'(u_q);
        end
        4'd1: begin
          mul_a = MUL_A_BITS'(l_q);
          mul_b = MUL_B_BITS'(l_q);
        end
        4'd2: begin
          mul_a = MUL_A_BITS'(m_q[0]);
          mul_b = MUL_B_BITS'(u_q);
        end
        4'd3: begin
          mul_a = MUL_A_BITS'(m_q[0]);
          mul_b = MUL_B_BITS'(l_q);
        end
        4'd4: begin
          mul_a = MUL_A_BITS'(m_q[1]);
          mul_b = MUL_B_BITS'(u_q);
        end
        default: begin
          mul_a = MUL_A_BITS'(m_q[1]);
          mul_b = MUL_B_BITS'(l_q);
        end
      endcase
    end
  end

  // Blend weights from the power products
  logic signed [WEIGHT_BITS-1:0] fS, f2S, f3S, m3S, m4S;
  logic signed [WEIGHT_BITS-1:0] wn [BLEND_TAPS];

  always_comb begin
    fS  = WEIGHT_BITS'(u_q);
    f2S = WEIGHT_BITS'(m_q[0]);
    f3S = WEIGHT_BITS'(m_q[2]);
    m3S = WEIGHT_BITS'(m_q[3]);
    m4S = WEIGHT_BITS'(m_q[4]);
    if (cfg_mode == MODE_CATMULL) begin
      wn[0] = -(fS <<< 32) + (f2S <<< 17) - f3S;
      wn[1] = (WEIGHT_BITS'(1) <<< 49) - ((f2S <<< 18) + (f2S <<< 16))
            + ((f3S <<< 1) + f3S);
      wn[2] = (fS <<< 32) + (f2S <<< 18) - ((f3S <<< 1) + f3S);
      wn[3] = -(f2S <<< 16) + f3S;
    end else begin
      wn[0] = f3S;
      wn[1] = (m3S <<< 1) + m3S;
      wn[2] = (m4S <<< 1) + m4S;
      wn[3] = WEIGHT_BITS'(m_q[5]);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode  <= MODE_BEZIER;
      cfg_knots <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:  cfg_mode  <= wr_data[0];
        REG_KNOTS: cfg_knots <= wr_data;
        default:   cfg_knots <= cfg_knots;
      endcase
    end
  end

  // Knot memory: write on a write beat, registered read per tap
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CHECK && is_write && !slot_bad) begin
      knot_mem[IW'(item_q.knot_index)] <= {sat_knot(item_q.knot_z),
                                           sat_knot(item_q.knot_y),
                                           sat_knot(item_q.knot_x)};
    end
    if (cmd.op == OP_READ) begin
      rd_q <= knot_mem[IW'(idx_q[cmd.knot])];
    end
  end

  // Multiplier pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= (cmd.op == OP_WMUL) || (cmd.op == OP_BLEND);
    end
  end

  // Item, segment, weight and accumulator registers
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    pblend <= (cmd.op == OP_BLEND);
    ptag   <= cmd.step;

    // Retire the previous product
    if (pvalid) begin
      if (pblend) begin
        unique case (ptag[1:0])
          2'd0: acc_q[ptag[3:2]] <= acc_q[ptag[3:2]] + ACCW'(prod_q);
          2'd1: acc_q[ptag[3:2]] <= acc_q[ptag[3:2]] + (ACCW'(prod_q) <<< CL);
          2'd2: acc_q[ptag[3:2]] <= acc_q[ptag[3:2]] + (ACCW'(prod_q) <<< WLO_BITS);
          default: acc_q[ptag[3:2]] <= acc_q[ptag[3:2]]
                                     + (ACCW'(prod_q) <<< (WLO_BITS + CL));
        endcase
      end else begin
        m_q[3'(ptag)] <= prod_q[MREG_BITS-1:0];
      end
    end

    unique case (cmd.op)
      OP_LOAD: item_q <= item;
      OP_CHECK: begin
        if (stat.finish) begin
          result_q <= '{point_x: '0, point_y: '0, point_z: '0, status: status_c};
        end
      end
      OP_PARAM: begin
        s_q  <= div3(nm1);
        tn_q <= 23'(t_sat) * 23'(nm1);
      end
      OP_SPLIT: begin
        if (cfg_mode == MODE_CATMULL) begin
          u_q      <= {1'b0, tn_q[15:0]};
          l_q      <= '0;
          idx_q[0] <= i0;
          idx_q[1] <= p1;
          idx_q[2] <= i2;
          idx_q[3] <= i3;
        end else begin
          l_q      <= lw[16:0];
          u_q      <= ONE_Q16 - lw[16:0];
          idx_q[0] <= seg7;
          idx_q[1] <= seg7 + 7'd1;
          idx_q[2] <= seg7 + 7'd2;
          idx_q[3] <= seg7 + 7'd3;
        end
      end
      OP_WFIN: begin
        for (int k = 0; k < BLEND_TAPS; k++) begin
          w_q[k] <= wn[k];
        end
        for (int a = 0; a < 3; a++) begin
          acc_q[a] <= '0;
        end
      end
      OP_ROUND: begin
        result_q <= '{point_x: finish_axis(acc_q[0], cfg_mode),
                      point_y: finish_axis(acc_q[1], cfg_mode),
                      point_z: finish_axis(acc_q[2], cfg_mode),
                      status:  STATUS_OK};
      end
      default: ;
    endcase
  end

  assign result = result_q;

endmodule

`default_nettype wire

FILE: hdl/spline_point_evaluator.sv
// Top level of the spline point evaluator.
//
// Each beat taken on start (while busy is low) is either a knot write or a
// point evaluation, and produces exactly one result beat, flagged by done for
// a single cycle; results cannot be held off, so capture them when done is
// high. A knot write (or any evaluation rejected for too few knots or an
// out-of-range knot count) returns its result from the check step. A
// full evaluation runs these steps in order: setup and segment
// selection, six steps of the shared multiplier to build the four blend
// weights, then one knot memory read plus twelve multiplier steps for each of
// the four knots (four partial products per axis). One item is in flight at a
// time; a new start may be given in the same cycle as done. Configuration
// writes take effect at once and must only be made while the block is idle.
`default_nettype none

module spline_point_evaluator #(
  parameter int MAX_KNOTS  = spe_pkg::MAX_KNOTS_DEF,
  parameter int COORD_BITS = spe_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire spe_pkg::item_t                 item,
  output logic                                done,
  output spe_pkg::result_t                    result,
  input  wire logic                           wr_en,
  input  wire logic                           wr_index,
  input  wire logic [spe_pkg::COUNT_BITS-1:0] wr_data
);
  import spe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence one beat at a time
  spe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold knots and do the arithmetic
  spe_datapath #(
    .MAX_KNOTS  (MAX_KNOTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result)
  );

endmodule

`default_nettype wire
